>>> hdl/trilin_pkg.sv
// Package for the trilinear interpolation core.
// Holds the default sample and fraction widths and the pipeline latency.
// No dependencies.
package trilin_pkg;

	// Default width of one corner sample and of the result, in bits.
	localparam int unsigned SAMPLE_BITS_DEF = 16;

	// Default number of fraction bits in a weight; the weight port is one bit wider.
	localparam int unsigned FRACTION_BITS_DEF = 16;

	// Register stages from an accepted item to its result strobe.
	localparam int unsigned PIPE_LATENCY = 7;

endpackage : trilin_pkg

>>> hdl/trilinear_interpolate_core.sv
// Each accepted item passes through all the register stages; its result is presented from the last.
// Throughput: one item per clock cycle; busy is always low, so start may be held high indefinitely.
// There are seven register stages; stages two, four and six hold the products.
// The receiver cannot stall: every result appears for one cycle with done high.
// Reset (arst_n low, asynchronous) clears all valid bits. Items in flight are dropped.
// Depends on trilin_pkg for the default widths and the pipeline latency.
module trilinear_interpolate_core #(
	parameter int unsigned SAMPLE_BITS   = trilin_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned FRACTION_BITS = trilin_pkg::FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic        [FRACTION_BITS:0]   frac_x,
	input  logic        [FRACTION_BITS:0]   frac_y,
	input  logic        [FRACTION_BITS:0]   frac_z,
	input  logic signed [SAMPLE_BITS-1:0]   corner_000,
	input  logic signed [SAMPLE_BITS-1:0]   corner_010,
	input  logic signed [SAMPLE_BITS-1:0]   corner_100,
	input  logic signed [SAMPLE_BITS-1:0]   corner_110,
	input  logic signed [SAMPLE_BITS-1:0]   corner_001,
	input  logic signed [SAMPLE_BITS-1:0]   corner_011,
	input  logic signed [SAMPLE_BITS-1:0]   corner_101,
	input  logic signed [SAMPLE_BITS-1:0]   corner_111,
	output logic                            done,
	output logic signed [SAMPLE_BITS-1:0]   blended_value
);
	import trilin_pkg::*;

	// Every blend w0*a + w1*b is rewritten as a*2^F + w1*(b - a), using w0 = 2^F - w1.
	// This needs one multiplier per blend and gives exactly the same sum.
	// The sum is rounded to nearest, with ties going towards plus infinity. This is done by
	// adding half an LSB and then taking the bits above the fraction with an arithmetic cut.
	// A convex blend of in-range samples stays in range, so the intermediate results are
	// kept at the sample width. The clamp is applied only to the final result.

	localparam int unsigned DW = SAMPLE_BITS + 1;                  // corner difference
	localparam int unsigned WW = FRACTION_BITS + 1;                // weight, up to 1.0
	localparam int unsigned PW = SAMPLE_BITS + FRACTION_BITS + 3;  // product and sum
	localparam int unsigned RW = PW - FRACTION_BITS;               // rounded result

	localparam logic [WW-1:0] ONE_W = WW'(1) << FRACTION_BITS;
	localparam logic signed [PW-1:0] HALF_LSB = PW'(1) << (FRACTION_BITS - 1);
	localparam logic signed [RW-1:0] MAX_OUT = RW'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [RW-1:0] MIN_OUT = -MAX_OUT - RW'(1);

	// The pipeline never stalls, so an item is taken whenever start is high.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Stage 1: clamp the weights and form the four differences along y.
	logic [WW-1:0] wx_in, wy_in, wz_in;
	always_comb begin
		wx_in = (frac_x > ONE_W) ? ONE_W : frac_x;
		wy_in = (frac_y > ONE_W) ? ONE_W : frac_y;
		wz_in = (frac_z > ONE_W) ? ONE_W : frac_z;
	end

	logic                           valid_s1;
	logic        [WW-1:0]           wx_s1, wy_s1, wz_s1;
	logic signed [SAMPLE_BITS-1:0]  a00_s1, a10_s1, a01_s1, a11_s1;
	logic signed [DW-1:0]           d00_s1, d10_s1, d01_s1, d11_s1;

	always_ff @(posedge clk) begin
		wx_s1  <= wx_in;
		wy_s1  <= wy_in;
		wz_s1  <= wz_in;
		a00_s1 <= corner_000;
		a10_s1 <= corner_100;
		a01_s1 <= corner_001;
		a11_s1 <= corner_101;
		d00_s1 <= DW'(corner_010) - DW'(corner_000);
		d10_s1 <= DW'(corner_110) - DW'(corner_100);
		d01_s1 <= DW'(corner_011) - DW'(corner_001);
		d11_s1 <= DW'(corner_111) - DW'(corner_101);
	end

	// Stage 2: four products along y.
	logic                           valid_s2;
	logic        [WW-1:0]           wx_s2, wz_s2;
	logic signed [SAMPLE_BITS-1:0]  a00_s2, a10_s2, a01_s2, a11_s2;
	logic signed [PW-1:0]           p00_s2, p10_s2, p01_s2, p11_s2;
	logic signed [WW:0]             wy_sgn;

	assign wy_sgn = $signed({1'b0, wy_s1});

	always_ff @(posedge clk) begin
		wx_s2  <= wx_s1;
		wz_s2  <= wz_s1;
		a00_s2 <= a00_s1;
		a10_s2 <= a10_s1;
		a01_s2 <= a01_s1;
		a11_s2 <= a11_s1;
		p00_s2 <= wy_sgn * d00_s1;
		p10_s2 <= wy_sgn * d10_s1;
		p01_s2 <= wy_sgn * d01_s1;
		p11_s2 <= wy_sgn * d11_s1;
	end

	// Stage 3: round the y blends, then form the differences along x.
	logic signed [PW-1:0] sy00, sy10, sy01, sy11;
	logic signed [RW-1:0] ry00, ry10, ry01, ry11;
	always_comb begin
		sy00 = (PW'(a00_s2) <<< FRACTION_BITS) + p00_s2 + HALF_LSB;
		sy10 = (PW'(a10_s2) <<< FRACTION_BITS) + p10_s2 + HALF_LSB;
		sy01 = (PW'(a01_s2) <<< FRACTION_BITS) + p01_s2 + HALF_LSB;
		sy11 = (PW'(a11_s2) <<< FRACTION_BITS) + p11_s2 + HALF_LSB;
		ry00 = sy00[PW-1:FRACTION_BITS];
		ry10 = sy10[PW-1:FRACTION_BITS];
		ry01 = sy01[PW-1:FRACTION_BITS];
		ry11 = sy11[PW-1:FRACTION_BITS];
	end

	logic                           valid_s3;
	logic        [WW-1:0]           wx_s3, wz_s3;
	logic signed [SAMPLE_BITS-1:0]  e00_s3, e01_s3;
	logic signed [DW-1:0]           dlo_s3, dhi_s3;

	always_ff @(posedge clk) begin
		wx_s3  <= wx_s2;
		wz_s3  <= wz_s2;
		e00_s3 <= ry00[SAMPLE_BITS-1:0];
		e01_s3 <= ry01[SAMPLE_BITS-1:0];
		dlo_s3 <= ry10[DW-1:0] - ry00[DW-1:0];
		dhi_s3 <= ry11[DW-1:0] - ry01[DW-1:0];
	end

	// Stage 4: two products along x.
	logic                           valid_s4;
	logic        [WW-1:0]           wz_s4;
	logic signed [SAMPLE_BITS-1:0]  e00_s4, e01_s4;
	logic signed [PW-1:0]           plo_s4, phi_s4;
	logic signed [WW:0]             wx_sgn;

	assign wx_sgn = $signed({1'b0, wx_s3});

	always_ff @(posedge clk) begin
		wz_s4  <= wz_s3;
		e00_s4 <= e00_s3;
		e01_s4 <= e01_s3;
		plo_s4 <= wx_sgn * dlo_s3;
		phi_s4 <= wx_sgn * dhi_s3;
	end

	// Stage 5: round the x blends and form the difference along z.
	logic signed [PW-1:0] sxlo, sxhi;
	logic signed [RW-1:0] rxlo, rxhi;
	always_comb begin
		sxlo = (PW'(e00_s4) <<< FRACTION_BITS) + plo_s4 + HALF_LSB;
		sxhi = (PW'(e01_s4) <<< FRACTION_BITS) + phi_s4 + HALF_LSB;
		rxlo = sxlo[PW-1:FRACTION_BITS];
		rxhi = sxhi[PW-1:FRACTION_BITS];
	end

	logic                           valid_s5;
	logic        [WW-1:0]           wz_s5;
	logic signed [SAMPLE_BITS-1:0]  lowz_s5;
	logic signed [DW-1:0]           dz_s5;

	always_ff @(posedge clk) begin
		wz_s5   <= wz_s4;
		lowz_s5 <= rxlo[SAMPLE_BITS-1:0];
		dz_s5   <= rxhi[DW-1:0] - rxlo[DW-1:0];
	end

	// Stage 6: the product along z.
	logic                           valid_s6;
	logic signed [SAMPLE_BITS-1:0]  lowz_s6;
	logic signed [PW-1:0]           pz_s6;
	logic signed [WW:0]             wz_sgn;

	assign wz_sgn = $signed({1'b0, wz_s5});

	always_ff @(posedge clk) begin
		lowz_s6 <= lowz_s5;
		pz_s6   <= wz_sgn * dz_s5;
	end

	// Stage 7: round the z blend, clamp it to the sample range and present it with done.
	logic signed [PW-1:0]          sz;
	logic signed [RW-1:0]          rz;
	logic signed [SAMPLE_BITS-1:0] clamped;
	always_comb begin
		sz = (PW'(lowz_s6) <<< FRACTION_BITS) + pz_s6 + HALF_LSB;
		rz = sz[PW-1:FRACTION_BITS];
		if (rz > MAX_OUT) begin
			clamped = MAX_OUT[SAMPLE_BITS-1:0];
		end else if (rz < MIN_OUT) begin
			clamped = MIN_OUT[SAMPLE_BITS-1:0];
		end else begin
			clamped = rz[SAMPLE_BITS-1:0];
		end
	end

	logic signed [SAMPLE_BITS-1:0] value_s7;

	always_ff @(posedge clk) begin
		value_s7 <= clamped;
	end

	// Valid bits travel alongside the data; they are the only state that reset clears.
	logic valid_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	assign done          = valid_s7;
	assign blended_value = value_s7;

`ifndef SYNTHESIS
	// A result strobe must always be traced back to an accepted item.
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, PIPE_LATENCY))
		else $error("done without an item accepted at the pipeline latency");

	// Every accepted item must produce its result after exactly the pipeline latency.
	a_item_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LATENCY done)
		else $error("accepted item produced no result");

	// If all eight corners are equal, every blend of them must return that same value.
	a_flat_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(start && corner_000 == corner_010 && corner_000 == corner_100 &&
		 corner_000 == corner_110 && corner_000 == corner_001 &&
		 corner_000 == corner_011 && corner_000 == corner_101 &&
		 corner_000 == corner_111)
		|-> ##PIPE_LATENCY (blended_value == $past(corner_000, PIPE_LATENCY)))
		else $error("flat cell did not return its corner value");

	// If all fractions are zero, the result must be the low corner.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(start && frac_x == '0 && frac_y == '0 && frac_z == '0)
		|-> ##PIPE_LATENCY (blended_value == $past(corner_000, PIPE_LATENCY)))
		else $error("zero fractions did not return the low corner");
`endif

endmodule : trilinear_interpolate_core

>>> tb/tb_trilinear_interpolate_core.sv
// Self-checking testbench for trilinear_interpolate_core: directed corner cases, then random
// cell queries with random idle gaps, each result checked against a bit-exact blend predictor.
// Depends on trilin_pkg and trilinear_interpolate_core.
`timescale 1ns / 1ps

module tb_trilinear_interpolate_core;

	import trilin_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam int FB = FRACTION_BITS_DEF;

	// 1.0 in weight format, and the rounding offset of one blend stage.
	localparam longint WEIGHT_ONE = longint'(1) << FB;
	localparam longint ROUND_HALF = longint'(1) << (FB - 1);

	localparam longint SAMPLE_MAX = (longint'(1) << (SB - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	localparam int N_DIRECTED_MAX = 25;
	localparam int N_QUERIES      = 1150;

	// A cycle count with no item accepted and no result seen that can only mean a hang.
	localparam int STALL_LIMIT = 500;

	// One cell query: three positions inside the cell and its eight corner samples.
	typedef struct {
		logic        [FB:0]   fx;
		logic        [FB:0]   fy;
		logic        [FB:0]   fz;
		logic signed [SB-1:0] c000;
		logic signed [SB-1:0] c010;
		logic signed [SB-1:0] c100;
		logic signed [SB-1:0] c110;
		logic signed [SB-1:0] c001;
		logic signed [SB-1:0] c011;
		logic signed [SB-1:0] c101;
		logic signed [SB-1:0] c111;
	} cell_query_t;

	// Holds the blended values that the accepted queries should produce, oldest first,
	// and compares each result strobe against the head of the queue.
	class blend_scoreboard;
		logic signed [SB-1:0] blend_q[$];
		int unsigned          mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Fractions above one are clamped to one.
		function longint weight_of(logic [FB:0] raw);
			longint w;
			w = longint'(raw);
			return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
		endfunction

		// One blend stage: exact weighted sum, then round to nearest with ties upwards.
		// An arithmetic shift of a signed sum is the floor division that is wanted.
		function longint lerp_round(longint w1, longint a, longint b);
			longint s;
			s = (WEIGHT_ONE - w1) * a + w1 * b;
			return (s + ROUND_HALF) >>> FB;
		endfunction

		function logic signed [SB-1:0] trilinear_blend(cell_query_t q);
			longint wx;
			longint wy;
			longint wz;
			longint e00;
			longint e10;
			longint e01;
			longint e11;
			longint low_z;
			longint high_z;
			longint v;
			wx = weight_of(q.fx);
			wy = weight_of(q.fy);
			wz = weight_of(q.fz);
			e00 = lerp_round(wy, q.c000, q.c010);
			e10 = lerp_round(wy, q.c100, q.c110);
			e01 = lerp_round(wy, q.c001, q.c011);
			e11 = lerp_round(wy, q.c101, q.c111);
			low_z  = lerp_round(wx, e00, e10);
			high_z = lerp_round(wx, e01, e11);
			v = lerp_round(wz, low_z, high_z);
			if (v > SAMPLE_MAX)
				v = SAMPLE_MAX;
			if (v < SAMPLE_MIN)
				v = SAMPLE_MIN;
			return v[SB-1:0];
		endfunction

		function void note_query(cell_query_t q);
			blend_q.push_back(trilinear_blend(q));
		endfunction

		function void check_result(logic signed [SB-1:0] got);
			logic signed [SB-1:0] want;
			if (blend_q.size() == 0) begin
				$error("blended_value: no result expected, actual %0d", got);
				mismatches++;
			end else begin
				want = blend_q.pop_front();
				if (got !== want) begin
					$error("blended_value: expected %0d, actual %0d", want, got);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return blend_q.size();
		endfunction
	endclass

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start  = 1'b0;
	logic        [FB:0]   frac_x = '0;
	logic        [FB:0]   frac_y = '0;
	logic        [FB:0]   frac_z = '0;
	logic signed [SB-1:0] corner_000 = '0;
	logic signed [SB-1:0] corner_010 = '0;
	logic signed [SB-1:0] corner_100 = '0;
	logic signed [SB-1:0] corner_110 = '0;
	logic signed [SB-1:0] corner_001 = '0;
	logic signed [SB-1:0] corner_011 = '0;
	logic signed [SB-1:0] corner_101 = '0;
	logic signed [SB-1:0] corner_111 = '0;
	logic                 busy;
	logic                 done;
	logic signed [SB-1:0] blended_value;

	blend_scoreboard blend_sb = new();
	int              stall_cycles = 0;
	cell_query_t     directed_q[$];

	always #6 clk = ~clk;

	trilinear_interpolate_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.frac_x        (frac_x),
		.frac_y        (frac_y),
		.frac_z        (frac_z),
		.corner_000    (corner_000),
		.corner_010    (corner_010),
		.corner_100    (corner_100),
		.corner_110    (corner_110),
		.corner_001    (corner_001),
		.corner_011    (corner_011),
		.corner_101    (corner_101),
		.corner_111    (corner_111),
		.done          (done),
		.blended_value (blended_value)
	);

	// Monitor. Everything is sampled at the rising edge, before the nonblocking updates of
	// that edge land, so the values seen are the ones the block itself registers. An item
	// is taken when start is high and busy low; a result is taken whenever done is high.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				blend_sb.note_query('{frac_x, frac_y, frac_z, corner_000, corner_010,
					corner_100, corner_110, corner_001, corner_011, corner_101, corner_111});
			if (done)
				blend_sb.check_result(blended_value);
		end
		// The watchdog restarts on any handshake in either direction.
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Puts a query on the ports and holds it until the block takes it. Start is left high
	// afterwards; the caller lowers it only when it decides on an idle gap, so start never
	// sees a fall and a rise within the same time step.
	task automatic send_query(cell_query_t q);
		start      <= 1'b1;
		frac_x     <= q.fx;
		frac_y     <= q.fy;
		frac_z     <= q.fz;
		corner_000 <= q.c000;
		corner_010 <= q.c010;
		corner_100 <= q.c100;
		corner_110 <= q.c110;
		corner_001 <= q.c001;
		corner_011 <= q.c011;
		corner_101 <= q.c101;
		corner_111 <= q.c111;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Positions lean towards the ends of the cell and the exact midpoint, where rounding
	// and the weight complement are most likely to go wrong; a few use the full port
	// width so that fractions above one, and the top bit, are exercised.
	function automatic logic [FB:0] random_frac();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return '0;
		if (pick < 16)
			return WEIGHT_ONE[FB:0];
		if (pick < 20)
			return ROUND_HALF[FB:0];
		if (pick < 24)
			return ($urandom_range(1)) ? (FB+1)'(1) : (FB+1)'(WEIGHT_ONE - 1);
		if (pick < 32)
			return (FB+1)'($urandom_range((1 << (FB + 1)) - 1));
		return (FB+1)'($urandom_range(int'(WEIGHT_ONE)));
	endfunction

	function automatic logic signed [SB-1:0] random_corner();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 6)
			return SAMPLE_MAX[SB-1:0];
		if (pick < 12)
			return SAMPLE_MIN[SB-1:0];
		return SB'($urandom());
	endfunction

	function automatic cell_query_t random_query();
		cell_query_t q;
		q.fx   = random_frac();
		q.fy   = random_frac();
		q.fz   = random_frac();
		q.c000 = random_corner();
		q.c010 = random_corner();
		q.c100 = random_corner();
		q.c110 = random_corner();
		q.c001 = random_corner();
		q.c011 = random_corner();
		q.c101 = random_corner();
		q.c111 = random_corner();
		return q;
	endfunction

	// Builds the directed set: each position at either end selects a single corner, the
	// midpoint gives rounding ties, fractions above one must behave as one, and corners at
	// both extremes of the sample range test the final clamp.
	task automatic build_directed();
		localparam logic [FB:0] F_ONE  = WEIGHT_ONE[FB:0];
		localparam logic [FB:0] F_HALF = ROUND_HALF[FB:0];
		localparam logic signed [SB-1:0] S_MAX = SAMPLE_MAX[SB-1:0];
		localparam logic signed [SB-1:0] S_MIN = SAMPLE_MIN[SB-1:0];
		cell_query_t q;
		cell_query_t base;
		base = '{'0, '0, '0, 16'sd100, -16'sd200, 16'sd300, -16'sd400,
			16'sd500, -16'sd600, 16'sd700, -16'sd800};
		// Each of the eight corners picked out by positions at the cell faces.
		for (int k = 0; k < 8; k++) begin
			q = base;
			q.fx = k[2] ? F_ONE : '0;
			q.fy = k[1] ? F_ONE : '0;
			q.fz = k[0] ? F_ONE : '0;
			directed_q.push_back(q);
		end
		// Fractions above one, including the largest the port can carry.
		q = base;
		q.fx = F_ONE + 1'b1;
		q.fy = '1;
		q.fz = F_ONE + F_HALF;
		directed_q.push_back(q);
		// All corners at the positive and at the negative extreme.
		q = '{F_HALF, 17'd1, F_ONE - 1'b1, S_MAX, S_MAX, S_MAX, S_MAX,
			S_MAX, S_MAX, S_MAX, S_MAX};
		directed_q.push_back(q);
		q = '{17'd1, F_ONE - 1'b1, F_HALF, S_MIN, S_MIN, S_MIN, S_MIN,
			S_MIN, S_MIN, S_MIN, S_MIN};
		directed_q.push_back(q);
		// Alternating extremes at the centre of the cell.
		q = '{F_HALF, F_HALF, F_HALF, S_MIN, S_MAX, S_MAX, S_MIN,
			S_MAX, S_MIN, S_MIN, S_MAX};
		directed_q.push_back(q);
		q = '{F_HALF, F_HALF, F_HALF, S_MAX, S_MIN, S_MIN, S_MAX,
			S_MIN, S_MAX, S_MAX, S_MIN};
		directed_q.push_back(q);
		// Odd neighbours at the midpoint: the y blends land exactly on a half, positive
		// and negative, so ties must go upwards.
		q = '{F_HALF, F_HALF, F_HALF, 16'sd0, 16'sd1, 16'sd0, 16'sd1,
			16'sd0, 16'sd1, 16'sd0, 16'sd1};
		directed_q.push_back(q);
		q = '{F_HALF, F_HALF, F_HALF, 16'sd0, -16'sd1, -16'sd1, -16'sd2,
			-16'sd3, -16'sd4, -16'sd5, -16'sd6};
		directed_q.push_back(q);
		// Smallest and largest weights short of the ends.
		q = '{17'd1, 17'd1, 17'd1, S_MIN, S_MAX, S_MAX, S_MAX,
			S_MAX, S_MAX, S_MAX, S_MAX};
		directed_q.push_back(q);
		q = '{F_ONE - 1'b1, F_ONE - 1'b1, F_ONE - 1'b1, S_MIN, S_MIN, S_MIN, S_MIN,
			S_MIN, S_MIN, S_MIN, S_MAX};
		directed_q.push_back(q);
		// Everything zero.
		directed_q.push_back('{'0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0});
	endtask

	// Random idle cycles before an item: each cycle is idle with a chance of 37 in a
	// hundred, so start is low in about that share of all cycles. The queries in the quiet
	// window go back to back.
	task automatic maybe_idle(int idx);
		if (!(idx >= 400 && idx < 650)) begin
			while ($urandom_range(99) < 37) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	initial begin
		int sent;
		sent = 0;
		build_directed();
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (directed_q.size() > 0 && sent < N_DIRECTED_MAX) begin
			maybe_idle(sent);
			send_query(directed_q.pop_front());
			sent++;
		end
		while (sent < N_QUERIES) begin
			maybe_idle(sent);
			send_query(random_query());
			sent++;
		end
		start <= 1'b0;

		// Drain the pipeline, then wait beyond the pipeline latency so that any stray
		// result strobe would be caught.
		while (blend_sb.pending() > 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 3)
			@(posedge clk);

		if (blend_sb.mismatches == 0 && blend_sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule : tb_trilinear_interpolate_core
